[hw/rtl/bvs_pkg.sv]
// Shared types and constants of the blowdown valve sequencer.
`default_nettype none
package bvs_pkg;
    localparam int Vessels = 8;
    localparam int TimeBits = 16;
    localparam int LevelBits = 12;
    localparam int LevelGap = 1;
    localparam int VidBits = 4;
    localparam int VIdxBits = 3;

    localparam logic [2:0] CFG_PULSE_LO = 3'd0;
    localparam logic [2:0] CFG_PULSE_HI = 3'd1;
    localparam logic [2:0] CFG_WAIT_LO  = 3'd2;
    localparam logic [2:0] CFG_WAIT_HI  = 3'd3;
    localparam logic [2:0] CFG_LVL_ON   = 3'd4;
    localparam logic [2:0] CFG_LVL_OFF  = 3'd5;

    // One classified tick handed from the front end to the sequencer.
    typedef struct packed {
        logic [Vessels-1:0]   toggles;
        logic                 run;
        logic                 pump_req;
        logic                 pump_tog;
        logic [LevelBits-1:0] level;
    } tick_t;

    // One result transaction.
    typedef struct packed {
        logic [Vessels-1:0] valves;
        logic               pump;
        logic [VidBits-1:0] active;
    } result_t;
endpackage
`default_nettype wire

[hw/rtl/bvs_front.sv]
// Front end: accepts ticks and queues them in a two-entry FIFO.
`default_nettype none
module bvs_front
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire bvs_pkg::tick_t    in_tick,
    output logic                   q_valid,
    input  wire logic              q_ready,
    output bvs_pkg::tick_t         q_tick
);
    bvs_pkg::tick_t mem_reg [2];
    logic           wr_ptr_reg, rd_ptr_reg;
    logic [1:0]     cnt_reg;

    assign in_ready = (cnt_reg != 2'd2);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_tick   = mem_reg[rd_ptr_reg];

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            mem_reg[wr_ptr_reg] <= in_tick;
        end
    end

    // Queue pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (q_valid && q_ready)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, in_valid && in_ready} - {1'b0, q_valid && q_ready};
        end
    end
endmodule
`default_nettype wire

[hw/rtl/bvs_back.sv]
// Back end: walks the vessels one per cycle, and with run set walks them again, then runs queue and pump logic.
`default_nettype none
module bvs_back
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [2:0]                     cfg_idx,
    input  wire logic [63:0]                    cfg_data,
    input  wire logic                           q_valid,
    output logic                                q_ready,
    input  wire bvs_pkg::tick_t                 q_tick,
    output logic                                res_valid,
    input  wire logic                           res_ready,
    output bvs_pkg::result_t                    res
);
    localparam int V = bvs_pkg::Vessels;
    localparam int TB = bvs_pkg::TimeBits;
    localparam int LB = bvs_pkg::LevelBits;
    localparam int VB = bvs_pkg::VidBits;
    localparam int IB = bvs_pkg::VIdxBits;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_TOG  = 3'd1;
    localparam logic [2:0] S_RUN  = 3'd2;
    localparam logic [2:0] S_FIN  = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [63:0]   pulse_lo_reg, pulse_hi_reg, wait_lo_reg, wait_hi_reg;
    logic [LB-1:0] lvl_on_reg, lvl_off_reg;

    logic [V-1:0]  auto_reg, waitp_reg, open_reg;
    logic [TB-1:0] elap_reg [V];
    logic [VB-1:0] q_reg [V];
    logic [VB-1:0] cur_reg;
    logic          pump_reg, pauto_reg;
    logic [2:0]    state_reg;
    logic [IB-1:0] idx_reg;
    bvs_pkg::tick_t tick_reg;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pulse_lo_reg <= '0;
            pulse_hi_reg <= '0;
            wait_lo_reg  <= '0;
            wait_hi_reg  <= '0;
            lvl_on_reg   <= '0;
            lvl_off_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                bvs_pkg::CFG_PULSE_LO: pulse_lo_reg <= cfg_data;
                bvs_pkg::CFG_PULSE_HI: pulse_hi_reg <= cfg_data;
                bvs_pkg::CFG_WAIT_LO:  wait_lo_reg  <= cfg_data;
                bvs_pkg::CFG_WAIT_HI:  wait_hi_reg  <= cfg_data;
                bvs_pkg::CFG_LVL_ON:   lvl_on_reg   <= cfg_data[LB-1:0];
                bvs_pkg::CFG_LVL_OFF:  lvl_off_reg  <= cfg_data[LB-1:0];
                default: ;
            endcase
        end
    end

    // Per-vessel time fields of the vessel being visited.
    logic [63:0]   p_word, w_word;
    logic [TB-1:0] pulse_t, wait_t;
    logic [VB-1:0] vid;
    assign p_word  = idx_reg[2] ? pulse_hi_reg : pulse_lo_reg;
    assign w_word  = idx_reg[2] ? wait_hi_reg : wait_lo_reg;
    assign pulse_t = p_word[{idx_reg[1:0], 4'd0} +: TB];
    assign wait_t  = w_word[{idx_reg[1:0], 4'd0} +: TB];
    assign vid     = {1'b0, idx_reg} + 4'd1;

    // Queue helpers: add and remove applied to a copy of the queue.
    function automatic void q_add(ref logic [VB-1:0] q [V], input logic [VB-1:0] v);
        logic done;
        done = 1'b0;
        for (int a = 0; a < V; a++)
        begin
            if (!done && (q[a] == '0 || q[a] == v))
            begin
                q[a] = v;
                done = 1'b1;
            end
        end
    endfunction

    function automatic void q_del(ref logic [VB-1:0] q [V], input logic [VB-1:0] v);
        logic hit;
        hit = 1'b0;
        for (int a = 0; a < V; a++)
        begin
            if (q[a] == v)
            begin
                hit = 1'b1;
            end
            if (hit)
            begin
                q[a] = (a + 1 < V) ? q[a + 1] : '0;
            end
        end
    endfunction

    logic [VB-1:0] qn [V];
    logic [V-1:0]  auto_next, waitp_next, open_next;
    logic [TB-1:0] el_next;
    logic [VB-1:0] cur_next;
    logic          pump_next;
    logic [VB-1:0] low_open;
    logic [LB:0]   min_on, on_lim;

    // Lowest open valve number.
    always_comb
    begin
        low_open = '0;
        for (int i = V - 1; i >= 0; i--)
        begin
            if (open_reg[i])
            begin
                low_open = VB'(i + 1);
            end
        end
    end

    assign min_on = {1'b0, lvl_off_reg} + (LB + 1)'(bvs_pkg::LevelGap);
    assign on_lim = ({1'b0, lvl_on_reg} < min_on) ? min_on : {1'b0, lvl_on_reg};

    // Next state of the visited vessel and the queue.
    always_comb
    begin
        logic w;
        for (int a = 0; a < V; a++)
        begin
            qn[a] = q_reg[a];
        end
        auto_next  = auto_reg;
        waitp_next = waitp_reg;
        open_next  = open_reg;
        el_next    = elap_reg[idx_reg];
        cur_next   = cur_reg;
        pump_next  = pump_reg;
        w          = waitp_reg[idx_reg];
        if (state_reg == S_TOG && tick_reg.toggles[idx_reg])
        begin
            if (!auto_reg[idx_reg])
            begin
                auto_next[idx_reg] = 1'b1;
                q_add(qn, vid);
            end
            else
            begin
                auto_next[idx_reg] = 1'b0;
                q_del(qn, vid);
            end
            el_next = '0;
            open_next[idx_reg] = 1'b0;
        end
        else if (state_reg == S_RUN && auto_reg[idx_reg])
        begin
            open_next[idx_reg] = 1'b0;
            if (cur_reg == vid && !w)
            begin
                if (el_next < pulse_t)
                begin
                    open_next[idx_reg] = 1'b1;
                    el_next = el_next + 1'b1;
                end
                else
                begin
                    w = 1'b1;
                    q_del(qn, vid);
                    el_next = '0;
                end
            end
            if (w)
            begin
                if (el_next < wait_t)
                begin
                    el_next = el_next + 1'b1;
                end
                else
                begin
                    w = 1'b0;
                    q_add(qn, vid);
                    el_next = '0;
                end
            end
            waitp_next[idx_reg] = w;
        end
        else if (state_reg == S_FIN)
        begin
            if (low_open == '0)
            begin
                cur_next = q_reg[0];
                if (q_reg[0] != '0)
                begin
                    q_del(qn, q_reg[0]);
                end
            end
            if (pauto_reg)
            begin
                if ({1'b0, tick_reg.level} >= on_lim && (low_open < 4'd1 || low_open > 4'd4))
                begin
                    pump_next = 1'b1;
                end
                if (tick_reg.level <= lvl_off_reg || low_open == 4'd4)
                begin
                    pump_next = 1'b0;
                end
            end
            else if (tick_reg.pump_tog)
            begin
                pump_next = ~pump_reg;
            end
        end
    end

    assign q_ready   = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_OUT);
    always_comb
    begin
        res.active = cur_reg;
        res.pump   = pump_reg;
        res.valves = open_reg;
    end

    // Sequencer state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
            auto_reg  <= '0;
            waitp_reg <= '0;
            open_reg  <= '0;
            cur_reg   <= '0;
            pump_reg  <= 1'b0;
            pauto_reg <= 1'b0;
            for (int a = 0; a < V; a++)
            begin
                elap_reg[a] <= '0;
                q_reg[a]    <= '0;
            end
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        tick_reg <= q_tick;
                        if (q_tick.pump_req != pauto_reg)
                        begin
                            pauto_reg <= q_tick.pump_req;
                            if (!q_tick.pump_req)
                            begin
                                pump_reg <= 1'b0;
                            end
                        end
                        idx_reg   <= '0;
                        state_reg <= S_TOG;
                    end
                end
                S_TOG, S_RUN:
                begin
                    auto_reg  <= auto_next;
                    waitp_reg <= waitp_next;
                    open_reg  <= open_next;
                    elap_reg[idx_reg] <= el_next;
                    for (int a = 0; a < V; a++)
                    begin
                        q_reg[a] <= qn[a];
                    end
                    idx_reg <= idx_reg + 1'b1;
                    if (idx_reg == IB'(V - 1))
                    begin
                        if (state_reg == S_TOG && tick_reg.run)
                        begin
                            state_reg <= S_RUN;
                        end
                        else if (state_reg == S_TOG)
                        begin
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            state_reg <= S_FIN;
                        end
                    end
                end
                S_FIN:
                begin
                    cur_reg  <= cur_next;
                    pump_reg <= pump_next;
                    for (int a = 0; a < V; a++)
                    begin
                        q_reg[a] <= qn[a];
                    end
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (res_ready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

[hw/rtl/blowdown_valve_sequencer_top.sv]
// Top level of the blowdown valve sequencer.
// A tick passes the front FIFO; the back end then walks the vessels to apply mode toggles and,
// with run set, walks them again and updates queue and pump before presenting the result.
// The back end takes no new tick until out_ready has taken the result of the last one.
// The front FIFO holds two ticks so the input side can run ahead of the back end.
// Reset (rst_n low, asynchronous) clears all vessel, queue, pump and config state.
`default_nettype none
module blowdown_valve_sequencer_top
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [63:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  mode_toggle_mask,
    input  wire logic        run_enable,
    input  wire logic        pump_auto_request,
    input  wire logic        pump_manual_toggle,
    input  wire logic [11:0] sump_level,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [7:0]       valve_mask,
    output logic             pump_on,
    output logic             pump_off_lamp,
    output logic [3:0]       active_vessel
);
    bvs_pkg::tick_t   in_tick, q_tick;
    bvs_pkg::result_t res;
    logic             q_valid, q_ready;

    always_comb
    begin
        in_tick.toggles  = mode_toggle_mask;
        in_tick.run      = run_enable;
        in_tick.pump_req = pump_auto_request;
        in_tick.pump_tog = pump_manual_toggle;
        in_tick.level    = sump_level;
    end

    bvs_front u_front
    (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .in_tick(in_tick), .q_valid(q_valid), .q_ready(q_ready), .q_tick(q_tick)
    );

    bvs_back u_back
    (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_idx(cfg_index),
        .cfg_data(cfg_data), .q_valid(q_valid), .q_ready(q_ready), .q_tick(q_tick),
        .res_valid(out_valid), .res_ready(out_ready), .res(res)
    );

    assign valve_mask    = res.valves;
    assign pump_on       = res.pump;
    assign pump_off_lamp = ~res.pump;
    assign active_vessel = res.active;

    // A presented result's valve mask and pump state hold until taken.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(valve_mask) && $stable(pump_on))
        else $error("result changed while stalled");

    // The active vessel is never above the vessel count.
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        active_vessel <= 4'd8)
        else $error("active vessel out of range");

    // Only the active vessel can have its valve open.
    a_lock: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (valve_mask != 8'd0) |->
            (valve_mask == (8'd1 << (active_vessel - 4'd1))))
        else $error("valve open on a vessel that is not active");
endmodule
`default_nettype wire
